// ===== rtl/csra_pkg.sv =====
package csra_pkg;

  localparam int unsigned ActionW = 2;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SRowW   = 4;
  localparam int unsigned SColW   = 5;
  localparam int unsigned StateW  = 2;

  localparam logic [ActionW-1:0] ACT_BUY    = 2'd0;
  localparam logic [ActionW-1:0] ACT_TOGGLE = 2'd1;
  localparam logic [ActionW-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [StateW-1:0] SEAT_FREE     = 2'd0;
  localparam logic [StateW-1:0] SEAT_RESERVED = 2'd1;
  localparam logic [StateW-1:0] SEAT_BOUGHT   = 2'd2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CFG_ROWS_IN_USE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_ROW_SEATS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_SEAT_STEP   = 2'd2;

  localparam logic [4:0] RowsInUseRst     = 5'd10;
  localparam logic [5:0] FirstRowSeatsRst = 6'd12;
  localparam logic [4:0] RowSeatStepRst   = 5'd1;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [CountW-1:0]  seat_count;
    logic [SRowW-1:0]   seat_row;
    logic [SColW-1:0]   seat_col;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [SRowW-1:0]   run_row;
    logic [SColW-1:0]   run_top_col;
    logic [StateW-1:0]  seat_state;
  } rsp_t;

endpackage

// ===== rtl/contiguous_seat_run_allocator.sv =====
// seat run allocator
// request channel: in_valid_i / in_stall_o carry one req_t (buy, toggle or clear).
// result channel: out_valid_o / out_stall_i carry one rsp_t per request.
// config channel: cfg_valid_i / cfg_ready_o write rows_in_use, first_row_seats and
// row_seat_step by index; write only while no request is in flight.
// the seat table lives in one synchronous memory, one row word per address, with a
// registered read. a buy reads one row per cycle from the top row down; the hit
// row is written back in its last scan cycle. a toggle reads the row, then writes
// it back; a clear and a rejected request are answered from idle with no memory access.
// one request is worked on at a time; in_stall_o is high while one is in progress.
// the result goes to an output register, so the next request is taken while it
// waits; if a second result finishes while the output is still stalled it is
// parked and the block holds in_stall_o until the output drains.
// reset clears every per-row valid flag (an invalid row reads as all seats
// available), sets the config registers to their defaults and empties the output.
// a clear request drops all row valid flags at once.
module contiguous_seat_run_allocator
  import csra_pkg::*;
#(
  parameter int unsigned ROWS     = 16,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  req_t                in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsp_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW   = $clog2(MAX_COLS);
  localparam int unsigned LENW = CW + 1;
  localparam int unsigned NW   = RW + 7;
  localparam int unsigned MaxRun = (1 << CountW) - 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TGL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  typedef logic [MAX_COLS-1:0][StateW-1:0] row_t;

  function automatic logic [LENW-1:0] row_len(input logic [RW-1:0] row,
                                              input logic [5:0] first,
                                              input logic [4:0] step);
    logic [NW-1:0] n;
    n = NW'(first) + NW'(row) * NW'(step);
    return (n > NW'(MAX_COLS)) ? LENW'(MAX_COLS) : LENW'(n);
  endfunction

  // config registers
  logic [4:0] rows_in_use_q;
  logic [5:0] first_row_seats_q;
  logic [4:0] row_seat_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_in_use_q     <= RowsInUseRst;
      first_row_seats_q <= FirstRowSeatsRst;
      row_seat_step_q   <= RowSeatStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ROWS_IN_USE:     rows_in_use_q     <= cfg_data_i[4:0];
        CFG_FIRST_ROW_SEATS: first_row_seats_q <= cfg_data_i;
        CFG_ROW_SEAT_STEP:   row_seat_step_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [6:0] nrows;
  assign nrows = (7'(rows_in_use_q) > 7'(ROWS)) ? 7'(ROWS) : 7'(rows_in_use_q);

  // seat memory and per-row valid flags
  row_t            mem [ROWS];
  logic [ROWS-1:0] row_vld_q, row_vld_d;
  row_t            rdata_q;
  logic            rvld_q;
  logic            rd_en, wr_en, clr;
  logic [RW-1:0]   rd_addr, wr_addr;
  row_t            wr_data;
  row_t            word;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    row_vld_d = row_vld_q;
    if (clr) begin
      row_vld_d = '0;
    end else if (wr_en) begin
      row_vld_d[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      row_vld_q <= row_vld_d;
      if (rd_en) begin
        rvld_q <= row_vld_q[rd_addr];
      end
    end
  end

  assign word = rvld_q ? rdata_q : '0;

  // control
  logic [1:0]        state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CW-1:0]     col_q, col_d;
  rsp_t              res_q, res_d, fin_rsp;
  rsp_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              fin, out_free, acc;

  assign acc      = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // run search on the row word in the read register
  logic [LENW-1:0]     scan_len;
  logic [MAX_COLS-1:0] free_v, ok_v;
  logic                hit;
  logic [CW-1:0]       top;
  row_t                bought_word;

  assign scan_len = row_len(row_q, first_row_seats_q, row_seat_step_q);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      free_v[c] = (word[c] == SEAT_FREE) && (LENW'(c) < scan_len);
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      ok_v[c] = (c + 1 >= int'(cnt_q));
      for (int i = 0; i < MaxRun; i++) begin
        if (i < int'(cnt_q)) begin
          if (c >= i) begin
            ok_v[c] = ok_v[c] && free_v[c - i];
          end else begin
            ok_v[c] = 1'b0;
          end
        end
      end
    end
    hit = 1'b0;
    top = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      if (ok_v[c]) begin
        hit = 1'b1;
        top = CW'(c);
      end
    end
    bought_word = word;
    for (int c = 0; c < MAX_COLS; c++) begin
      if ((c <= int'(top)) && (c + int'(cnt_q) > int'(top))) begin
        bought_word[c] = SEAT_BOUGHT;
      end
    end
  end

  // toggle checks on the incoming request
  logic [LENW-1:0]   tgl_len;
  logic              tgl_ok;
  logic [StateW-1:0] cur_seat, new_seat;
  row_t              tgl_word;

  assign tgl_len = row_len(RW'(in_data_i.seat_row), first_row_seats_q, row_seat_step_q);
  assign tgl_ok  = (7'(in_data_i.seat_row) < nrows) &&
                   (6'(in_data_i.seat_col) < 6'(tgl_len));

  always_comb begin
    cur_seat = word[col_q];
    case (cur_seat)
      SEAT_FREE:     new_seat = SEAT_RESERVED;
      SEAT_RESERVED: new_seat = SEAT_FREE;
      default:       new_seat = cur_seat;
    endcase
    tgl_word        = word;
    tgl_word[col_q] = new_seat;
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    col_d   = col_q;
    rd_en   = 1'b0;
    rd_addr = row_q;
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = bought_word;
    clr     = 1'b0;
    fin     = 1'b0;
    fin_rsp = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_data_i.action)
            ACT_BUY: begin
              if ((in_data_i.seat_count != '0) && (nrows != '0)) begin
                row_d   = RW'(nrows - 7'd1);
                cnt_d   = in_data_i.seat_count;
                rd_en   = 1'b1;
                rd_addr = RW'(nrows - 7'd1);
                state_d = S_SCAN;
              end else begin
                fin = 1'b1;
              end
            end
            ACT_TOGGLE: begin
              if (tgl_ok) begin
                row_d   = RW'(in_data_i.seat_row);
                col_d   = CW'(in_data_i.seat_col);
                rd_en   = 1'b1;
                rd_addr = RW'(in_data_i.seat_row);
                state_d = S_TGL;
              end else begin
                fin = 1'b1;
              end
            end
            ACT_CLEAR: begin
              clr = 1'b1;
              fin = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        // prefetch the next row down while this one is checked
        rd_en   = (row_q != '0);
        rd_addr = row_q - RW'(1);
        if (hit) begin
          wr_en               = 1'b1;
          fin                 = 1'b1;
          fin_rsp.granted     = 1'b1;
          fin_rsp.run_row     = SRowW'(row_q);
          fin_rsp.run_top_col = SColW'(top);
        end else if (row_q == '0) begin
          fin = 1'b1;
        end else begin
          row_d = row_q - RW'(1);
        end
      end
      S_TGL: begin
        wr_en              = 1'b1;
        wr_data            = tgl_word;
        fin                = 1'b1;
        fin_rsp.granted    = 1'b1;
        fin_rsp.seat_state = new_seat;
      end
      default: ;
    endcase

    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fin) begin
      if (out_free) begin
        out_d       = fin_rsp;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end else begin
        res_d   = fin_rsp;
        state_d = S_DONE;
      end
    end else if (state_q == S_DONE && out_free) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
      state_d     = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    cnt_q <= cnt_d;
    col_q <= col_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_write_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && clr))
    else $error("seat write and clear in the same cycle");

  a_scan_row_in_hall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (7'(row_q) < nrows))
    else $error("scan row outside the hall");

  a_parked_needs_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> out_valid_q)
    else $error("result parked while output register empty");

  a_toggle_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.seat_state != SEAT_FREE)) |->
      (out_data_o.granted && (out_data_o.run_row == '0) && (out_data_o.run_top_col == '0)))
    else $error("toggle result carries run fields");
`endif

endmodule

// ===== tb/tb_contiguous_seat_run_allocator.sv =====
`timescale 1ns / 100ps

module tb_contiguous_seat_run_allocator;
  import csra_pkg::*;

  localparam int unsigned SEAT_ROWS = 16;
  localparam int unsigned SEAT_COLS = 32;
  localparam int unsigned LIMIT     = 200000;
  localparam logic [ActionW-1:0] ACT_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE  = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  req_t                in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rsp_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  contiguous_seat_run_allocator #(
    .ROWS     (SEAT_ROWS),
    .MAX_COLS (SEAT_COLS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow of the hall: two status bits per seat
  logic [2*SEAT_COLS-1:0] hall_seats [SEAT_ROWS];
  logic [4:0]             hall_rows_cfg;
  logic [5:0]             first_seats_cfg;
  logic [4:0]             seat_step_cfg;

  req_t req_pend_q [$];
  rsp_t due_rsp_q  [$];

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          idle_on   = 1'b1;
  bit          hold_ask  = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic add_req(input req_t rq);
    req_pend_q = {req_pend_q, rq};
  endtask

  function automatic int seat_rows_now();
    return (hall_rows_cfg > SEAT_ROWS) ? SEAT_ROWS : hall_rows_cfg;
  endfunction

  function automatic int row_length(input int row);
    int n;
    n = first_seats_cfg + row * seat_step_cfg;
    return (n > SEAT_COLS) ? SEAT_COLS : n;
  endfunction

  function automatic rsp_t predict_seats(input req_t rq);
    rsp_t            rs;
    int              r, len, top, hi, i;
    bit              fit;
    logic [StateW-1:0] st;
    rs = '0;
    case (rq.action)
      ACT_BUY: begin
        r = seat_rows_now();
        // highest row first, then highest top column first
        while (rq.seat_count != 0 && r > 0 && !rs.granted) begin
          r--;
          len = row_length(r);
          top = len;
          while (top >= rq.seat_count && !rs.granted) begin
            hi = top - 1;
            fit = 1'b1;
            for (i = 0; i < rq.seat_count; i++)
              if (hall_seats[r][2*(hi-i) +: 2] != SEAT_FREE) fit = 1'b0;
            if (fit) begin
              for (i = 0; i < rq.seat_count; i++) hall_seats[r][2*(hi-i) +: 2] = SEAT_BOUGHT;
              rs.granted     = 1'b1;
              rs.run_row     = r[3:0];
              rs.run_top_col = hi[4:0];
            end
            top--;
          end
        end
      end
      ACT_TOGGLE: begin
        if (rq.seat_row < seat_rows_now() && rq.seat_col < row_length(int'(rq.seat_row))) begin
          st = hall_seats[rq.seat_row][2*rq.seat_col +: 2];
          if (st == SEAT_FREE) st = SEAT_RESERVED;
          else if (st == SEAT_RESERVED) st = SEAT_FREE;
          hall_seats[rq.seat_row][2*rq.seat_col +: 2] = st;
          rs.granted    = 1'b1;
          rs.seat_state = st;
        end
      end
      ACT_CLEAR: begin
        for (i = 0; i < SEAT_ROWS; i++) hall_seats[i] = '0;
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic req_t mk_req(input logic [ActionW-1:0] act, input int cnt,
                                  input int row, input int col);
    req_t rq;
    rq.action     = act;
    rq.seat_count = CountW'(cnt);
    rq.seat_row   = SRowW'(row);
    rq.seat_col   = SColW'(col);
    return rq;
  endfunction

  function automatic req_t random_req();
    req_t rq;
    int   sel, nrows, len;
    rq = mk_req(ActionW'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 31));
    sel = $urandom_range(0, 99);
    nrows = seat_rows_now();
    if (sel < 6) begin
      // noise: every field random
    end else if (sel < 52) begin
      rq.action = ACT_BUY;
      if ($urandom_range(0, 9) == 0) rq.seat_count = CountW'($urandom_range(0, 15));
      else rq.seat_count = CountW'($urandom_range(1, 9));
    end else if (sel < 95) begin
      rq.action = ACT_TOGGLE;
      // mostly aim at seats that exist
      if (nrows != 0 && $urandom_range(0, 3) != 0) begin
        rq.seat_row = SRowW'($urandom_range(0, nrows - 1));
        len = row_length(int'(rq.seat_row));
        if (len != 0) rq.seat_col = SColW'($urandom_range(0, len - 1));
      end
    end else if (sel < 98) begin
      rq.action = ACT_CLEAR;
    end else begin
      rq.action = ACT_UNUSED;
    end
    return rq;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_pend_q.size() != 0 || in_valid_i || due_rsp_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ROWS_IN_USE:     hall_rows_cfg   = val[4:0];
      CFG_FIRST_ROW_SEATS: first_seats_cfg = val[5:0];
      CFG_ROW_SEAT_STEP:   seat_step_cfg   = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_hall(input logic [CfgDataW-1:0] rows, input logic [CfgDataW-1:0] first,
                          input logic [CfgDataW-1:0] step);
    write_reg(CFG_ROWS_IN_USE, rows);
    write_reg(CFG_FIRST_ROW_SEATS, first);
    write_reg(CFG_ROW_SEAT_STEP, step);
  endtask

  task automatic run_random(input int n);
    repeat (n) add_req(random_req());
    wait_drained();
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) due_rsp_q = {due_rsp_q, predict_seats(in_data_i)};
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (req_pend_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= req_pend_q.pop_front();
          if (idle_on && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_rsp_q.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = due_rsp_q.pop_front();
          check_field("granted", 8'(out_data_o.granted), 8'(want.granted));
          check_field("run_row", 8'(out_data_o.run_row), 8'(want.run_row));
          check_field("run_top_col", 8'(out_data_o.run_top_col), 8'(want.run_top_col));
          check_field("seat_state", 8'(out_data_o.seat_state), 8'(want.seat_state));
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_ask) begin
        // long hold-off so the block backs up into its input
        hold_ask = 1'b0;
        out_stall_i <= 1'b1;
        hold_left   <= 100;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 6);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SEAT_ROWS; i++) hall_seats[i] = '0;
    hall_rows_cfg   = RowsInUseRst;
    first_seats_cfg = FirstRowSeatsRst;
    seat_step_cfg   = RowSeatStepRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset hall: rows 0..9, lengths 12..21
    add_req(mk_req(ACT_BUY, 0, 0, 0));
    add_req(mk_req(ACT_BUY, 9, 0, 0));
    add_req(mk_req(ACT_BUY, 1, 15, 31));
    add_req(mk_req(ACT_BUY, 15, 0, 0));
    add_req(mk_req(ACT_TOGGLE, 0, 9, 20));
    add_req(mk_req(ACT_TOGGLE, 0, 9, 0));
    add_req(mk_req(ACT_TOGGLE, 0, 9, 0));
    add_req(mk_req(ACT_TOGGLE, 15, 9, 0));
    add_req(mk_req(ACT_TOGGLE, 0, 10, 0));
    add_req(mk_req(ACT_TOGGLE, 0, 0, 12));
    add_req(mk_req(ACT_TOGGLE, 0, 0, 11));
    add_req(mk_req(ACT_TOGGLE, 0, 15, 31));
    add_req(mk_req(ACT_TOGGLE, 0, 0, 0));
    add_req(mk_req(ACT_UNUSED, 15, 15, 31));
    add_req(mk_req(ACT_BUY, 9, 15, 31));
    add_req(mk_req(ACT_CLEAR, 15, 15, 31));
    add_req(mk_req(ACT_BUY, 9, 0, 0));
    add_req(mk_req(ACT_TOGGLE, 0, 0, 0));
    wait_drained();

    // widest hall, with a long output hold-off
    set_hall(6'd16, 6'd32, 6'd0);
    hold_ask = 1'b1;
    run_random(60);

    // single one-seat row: counts above the row length fail
    set_hall(6'd1, 6'd1, 6'd0);
    add_req(mk_req(ACT_BUY, 2, 0, 0));
    add_req(mk_req(ACT_BUY, 1, 0, 0));
    add_req(mk_req(ACT_BUY, 1, 0, 0));
    add_req(mk_req(ACT_TOGGLE, 0, 0, 0));
    add_req(mk_req(ACT_TOGGLE, 0, 0, 1));
    add_req(mk_req(ACT_TOGGLE, 0, 1, 0));
    wait_drained();
    run_random(40);

    set_hall(6'd16, 6'd1, 6'd31);
    run_random(55);

    // out of range values, spare index is ignored
    write_reg(CFG_SPARE, 6'h3F);
    set_hall(6'h3F, 6'h3F, 6'h3F);
    run_random(50);

    // empty hall
    set_hall(6'd0, 6'd0, 6'd0);
    run_random(20);

    set_hall(6'h30, 6'd2, 6'd3);
    run_random(50);

    repeat (3) begin
      set_hall(CfgDataW'($urandom_range(1, 16)), CfgDataW'($urandom_range(1, 32)),
               CfgDataW'($urandom_range(0, 4)));
      run_random(55);
    end

    idle_on = 1'b0;
    set_hall(CfgDataW'(RowsInUseRst), CfgDataW'(FirstRowSeatsRst), CfgDataW'(RowSeatStepRst));
    run_random(60);

    repeat (2 * SEAT_ROWS + 8) @(posedge clk_i);
    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
